FILE: rtl/rpt_pkg.sv
// ============================================================================
// rpt_pkg: shared types and constants for the roast profile threshold timer
// Holds the register index codes, profile record, result record and the
// fixed constants of the countdown.
// ============================================================================
package rpt_pkg;

    localparam int unsigned TEMP_W   = 10;
    localparam int unsigned LENGTH_W = 13;
    localparam int unsigned MIN_W    = 7;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned DATA_W   = 13;

    localparam logic [TEMP_W-1:0]   NO_SWITCH_LIMIT = 10'd1000;
    localparam logic [LENGTH_W-1:0] MAX_LENGTH      = 13'd5999;
    localparam logic [SEC_W-1:0]    LAST_SECOND     = 6'd59;

    typedef enum logic [INDEX_W-1:0] {
        IDX_LIMIT_A  = 3'd0,
        IDX_LIMIT_B  = 3'd1,
        IDX_LIMIT_C  = 3'd2,
        IDX_LENGTH_A = 3'd3,
        IDX_LENGTH_B = 3'd4,
        IDX_LENGTH_C = 3'd5
    } cfg_index_t;

    // One profile: limit, saturated length and that length split as mm:ss
    typedef struct packed {
        logic [TEMP_W-1:0]   limit;
        logic [LENGTH_W-1:0] length;
        logic [MIN_W-1:0]    mins;
        logic [SEC_W-1:0]    secs;
    } profile_t;

    typedef struct packed {
        logic                show_time;
        logic [MIN_W-1:0]    minutes_left;
        logic [SEC_W-1:0]    seconds_left;
        logic [LENGTH_W-1:0] total_length;
        logic                running;
        logic                buzzer_on;
        logic                motor_one;
        logic                motor_two;
        logic                motor_three;
    } result_t;

endpackage

FILE: rtl/rpt_if.sv
// ============================================================================
// rpt_if: handshake channels of the roast profile threshold timer
// Tick input channel, result output channel and register write channel.
// ============================================================================
interface rpt_tick_if;
    logic        valid;
    logic        ready;
    logic [9:0]  temperature;
    logic        switch_a;
    logic        switch_b;
    logic        switch_c;

    modport source (output valid, temperature, switch_a, switch_b, switch_c, input ready);
    modport sink   (input valid, temperature, switch_a, switch_b, switch_c, output ready);
endinterface

interface rpt_result_if;
    logic        valid;
    logic        ready;
    logic        show_time;
    logic [6:0]  minutes_left;
    logic [5:0]  seconds_left;
    logic [12:0] total_length;
    logic        running;
    logic        buzzer_on;
    logic        motor_one;
    logic        motor_two;
    logic        motor_three;

    modport source (output valid, show_time, minutes_left, seconds_left, total_length,
                    running, buzzer_on, motor_one, motor_two, motor_three, input ready);
    modport sink   (input valid, show_time, minutes_left, seconds_left, total_length,
                    running, buzzer_on, motor_one, motor_two, motor_three, output ready);
endinterface

interface rpt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rpt_profile_regs.sv
// ============================================================================
// rpt_profile_regs: profile register file and profile select
// Holds the three limits and lengths, splits each length into mm:ss at write
// time, and picks the active profile from the switch bits (A over B over C).
// ============================================================================
module rpt_profile_regs (
    input  logic              clk,
    input  logic              rst_n,
    rpt_cfg_if.sink           cfg,
    input  logic              switch_a,
    input  logic              switch_b,
    input  logic              switch_c,
    output rpt_pkg::profile_t profile
);

    rpt_pkg::profile_t prof_a_reg, prof_b_reg, prof_c_reg;
    rpt_pkg::profile_t prof_a_next, prof_b_next, prof_c_next;

    logic                         cfg_fire;
    logic [rpt_pkg::LENGTH_W-1:0] len_sat;
    logic [23:0]                  recip_prod;
    logic [rpt_pkg::MIN_W-1:0]    quot_est;
    logic [rpt_pkg::LENGTH_W-1:0] quot_times60;
    logic [rpt_pkg::LENGTH_W-1:0] rem_wide;
    logic [rpt_pkg::MIN_W-1:0]    rem_est;
    logic [rpt_pkg::MIN_W-1:0]    len_mins;
    logic [rpt_pkg::SEC_W-1:0]    len_secs;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    // Split the saturated length by 60: reciprocal estimate low by at most one
    assign len_sat      = (cfg.data > rpt_pkg::MAX_LENGTH) ? rpt_pkg::MAX_LENGTH : cfg.data;
    assign recip_prod   = 24'(len_sat) * 24'd1092;
    assign quot_est     = recip_prod[22:16];
    assign quot_times60 = {quot_est, 6'b0} - {4'b0, quot_est, 2'b0};
    assign rem_wide     = len_sat - quot_times60;
    assign rem_est      = rem_wide[6:0];

    always_comb
    begin
        if (rem_est >= 7'd60)
        begin
            len_mins = quot_est + 7'd1;
            len_secs = 6'(rem_est - 7'd60);
        end
        else
        begin
            len_mins = quot_est;
            len_secs = rem_est[5:0];
        end
    end

    always_comb
    begin
        prof_a_next = prof_a_reg;
        prof_b_next = prof_b_reg;
        prof_c_next = prof_c_reg;
        if (cfg_fire)
        begin
            case (rpt_pkg::cfg_index_t'(cfg.index))
                rpt_pkg::IDX_LIMIT_A:  prof_a_next.limit = cfg.data[9:0];
                rpt_pkg::IDX_LIMIT_B:  prof_b_next.limit = cfg.data[9:0];
                rpt_pkg::IDX_LIMIT_C:  prof_c_next.limit = cfg.data[9:0];
                rpt_pkg::IDX_LENGTH_A:
                begin
                    prof_a_next.length = len_sat;
                    prof_a_next.mins   = len_mins;
                    prof_a_next.secs   = len_secs;
                end
                rpt_pkg::IDX_LENGTH_B:
                begin
                    prof_b_next.length = len_sat;
                    prof_b_next.mins   = len_mins;
                    prof_b_next.secs   = len_secs;
                end
                rpt_pkg::IDX_LENGTH_C:
                begin
                    prof_c_next.length = len_sat;
                    prof_c_next.mins   = len_mins;
                    prof_c_next.secs   = len_secs;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prof_a_reg <= '{limit: 10'd30, length: 13'd12, mins: 7'd0, secs: 6'd12};
            prof_b_reg <= '{limit: 10'd50, length: 13'd12, mins: 7'd0, secs: 6'd12};
            prof_c_reg <= '{limit: 10'd70, length: 13'd12, mins: 7'd0, secs: 6'd12};
        end
        else
        begin
            prof_a_reg <= prof_a_next;
            prof_b_reg <= prof_b_next;
            prof_c_reg <= prof_c_next;
        end
    end

    // No switch: a limit that cannot start with a zero length
    always_comb
    begin
        if (switch_a)
            profile = prof_a_reg;
        else if (switch_b)
            profile = prof_b_reg;
        else if (switch_c)
            profile = prof_c_reg;
        else
            profile = '{limit: rpt_pkg::NO_SWITCH_LIMIT, length: '0, mins: '0, secs: '0};
    end

endmodule

FILE: rtl/roast_profile_threshold_timer_unit.sv
// ============================================================================
// roast_profile_threshold_timer_unit: roast profile threshold timer
// Starts an mm:ss countdown on a rising crossing of the profile limit, then
// sounds the buzzer and latches the extra motors.
// ============================================================================
//
//  Channel  Role  Handshake     Carries
//  -------  ----  ------------  -------------------------------------------
//  tick     sink  valid/ready   temperature, switch_a, switch_b, switch_c
//  result   src   valid/ready   show_time .. motor_three, one per tick item
//  cfg      sink  valid/ready   index, data (ready always high)
//
//  One item per cycle sustained while the result side does not stall; a tick
//  item passes the input register, then the result register, before its
//  result can be accepted.
//  Per-item logic is one compare stage, an mm:ss decrement and the response
//  and motor latches; lengths are split into minutes and seconds when the
//  register is written. A stalled result holds its register; the input stage
//  keeps taking items until both stages are full.
//  Reset clears the countdown, response and motor latches and loads the
//  default profile registers.
//
module roast_profile_threshold_timer_unit (
    input  logic          clk,
    input  logic          rst_n,
    rpt_tick_if.sink      tick,
    rpt_result_if.source  result,
    rpt_cfg_if.sink       cfg
);

    // Input stage
    logic                       s1_valid_reg;
    logic [rpt_pkg::TEMP_W-1:0] s1_temp_reg;
    logic                       s1_sw_a_reg, s1_sw_b_reg, s1_sw_c_reg;
    logic                       s1_fire;

    // Result stage
    logic                       out_valid_reg;
    rpt_pkg::result_t           res_reg, res_next;

    // Timer state
    logic [rpt_pkg::TEMP_W-1:0]   prev_temp_reg, prev_temp_next;
    logic [rpt_pkg::MIN_W-1:0]    min_reg, min_next;
    logic [rpt_pkg::SEC_W-1:0]    sec_reg, sec_next;
    logic [rpt_pkg::LENGTH_W-1:0] total_reg, total_next;
    logic                         cd_on_reg, cd_on_next;
    logic                         resp_reg, resp_next;
    logic                         extra_done_reg, extra_done_next;
    logic [2:0]                   motor_reg, motor_next;

    rpt_pkg::profile_t            profile;
    logic                         start;
    logic                         cd_active;
    logic [rpt_pkg::MIN_W-1:0]    cur_min;
    logic [rpt_pkg::SEC_W-1:0]    cur_sec;
    logic                         no_switch;

    rpt_profile_regs u_profile_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .switch_a (s1_sw_a_reg),
        .switch_b (s1_sw_b_reg),
        .switch_c (s1_sw_c_reg),
        .profile  (profile)
    );

    // Advance the input stage when the result register is free or drains
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tick.ready)
            s1_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            s1_temp_reg <= tick.temperature;
            s1_sw_a_reg <= tick.switch_a;
            s1_sw_b_reg <= tick.switch_b;
            s1_sw_c_reg <= tick.switch_c;
        end
    end

    // Per-tick update
    always_comb
    begin
        no_switch = !s1_sw_a_reg && !s1_sw_b_reg && !s1_sw_c_reg;

        // Start only on an upward crossing while idle, with a nonzero length
        start = (s1_temp_reg >= profile.limit) && (s1_temp_reg > prev_temp_reg)
                && (prev_temp_reg < profile.limit) && !cd_on_reg
                && (profile.length != '0);

        prev_temp_next  = s1_temp_reg;
        total_next      = start ? profile.length : total_reg;
        cur_min         = start ? profile.mins : min_reg;
        cur_sec         = start ? profile.secs : sec_reg;
        cd_active       = start || cd_on_reg;
        cd_on_next      = cd_active;
        resp_next       = resp_reg;
        extra_done_next = extra_done_reg;
        motor_next      = motor_reg | {2'b00, start};
        min_next        = cur_min;
        sec_next        = cur_sec;

        // Show, then count down; finish one tick after reaching zero
        if (cd_active)
        begin
            if (cur_min == '0 && cur_sec == '0)
            begin
                cd_on_next = 1'b0;
                resp_next  = 1'b1;
            end
            else if (cur_sec == '0)
            begin
                sec_next = rpt_pkg::LAST_SECOND;
                min_next = cur_min - 7'd1;
            end
            else
            begin
                sec_next = cur_sec - 6'd1;
            end
        end

        // Switch off drops the response
        if (no_switch)
        begin
            resp_next       = 1'b0;
            extra_done_next = 1'b0;
        end

        // Latch motors 2 and 3 once per response
        if (resp_next && !extra_done_next)
        begin
            motor_next      = motor_next | 3'b110;
            extra_done_next = 1'b1;
        end

        res_next.show_time    = cd_active;
        res_next.minutes_left = cd_active ? cur_min : '0;
        res_next.seconds_left = cd_active ? cur_sec : '0;
        res_next.total_length = total_next;
        res_next.running      = cd_on_next;
        res_next.buzzer_on    = resp_next;
        res_next.motor_one    = motor_next[0];
        res_next.motor_two    = motor_next[1];
        res_next.motor_three  = motor_next[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_temp_reg  <= '0;
            min_reg        <= '0;
            sec_reg        <= '0;
            total_reg      <= '0;
            cd_on_reg      <= 1'b0;
            resp_reg       <= 1'b0;
            extra_done_reg <= 1'b0;
            motor_reg      <= '0;
        end
        else if (s1_fire)
        begin
            prev_temp_reg  <= prev_temp_next;
            min_reg        <= min_next;
            sec_reg        <= sec_next;
            total_reg      <= total_next;
            cd_on_reg      <= cd_on_next;
            resp_reg       <= resp_next;
            extra_done_reg <= extra_done_next;
            motor_reg      <= motor_next;
        end
    end

    // Hold the result while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || result.ready)
            out_valid_reg <= s1_fire;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            res_reg <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.show_time    = res_reg.show_time;
    assign result.minutes_left = res_reg.minutes_left;
    assign result.seconds_left = res_reg.seconds_left;
    assign result.total_length = res_reg.total_length;
    assign result.running      = res_reg.running;
    assign result.buzzer_on    = res_reg.buzzer_on;
    assign result.motor_one    = res_reg.motor_one;
    assign result.motor_two    = res_reg.motor_two;
    assign result.motor_three  = res_reg.motor_three;

    // Motor latches never drop once set
    a_motor_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(motor_reg) & ~motor_reg) == 3'b000)
        else $error("motor latch dropped");

    // A running countdown always has motor 1 on
    a_run_motor: assert property (@(posedge clk) disable iff (!rst_n)
        cd_on_reg |-> motor_reg[0])
        else $error("countdown running without motor 1");

    // The seconds counter stays within a minute
    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg <= rpt_pkg::LAST_SECOND)
        else $error("seconds counter out of range");

    // A handled response has motors 2 and 3 on
    a_extra_motors: assert property (@(posedge clk) disable iff (!rst_n)
        extra_done_reg |-> (motor_reg[1] && motor_reg[2]))
        else $error("response handled without extra motors");

endmodule

FILE: tb/sv/roast_timer_checker.sv
// ----------------------------------------------------------------------------
// Roast timer result checker
// Watches the tick, result and register channels. Keeps its own copy of the
// profile registers and countdown state. Compares each result with the
// oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roast_timer_checker
    import rpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rpt_tick_if   tick,
    rpt_result_if result,
    rpt_cfg_if    cfg,
    output int    mismatches,
    output int    in_flight,
    output int    ticks_checked,
    output int    starts_seen,
    output int    alarms_seen
);

    localparam int unsigned SECS_PER_MINUTE = 60;

    // profile registers as last written
    logic [TEMP_W-1:0]   lim_a, lim_b, lim_c;
    logic [LENGTH_W-1:0] len_a, len_b, len_c;

    // countdown state
    logic [TEMP_W-1:0]   last_temp;
    logic [LENGTH_W-1:0] secs_to_go;
    logic [LENGTH_W-1:0] run_length;
    logic                counting;
    logic                alarm;
    logic                extra_done;
    logic [2:0]          motors;

    result_t expected_q [$];

    // Advance the countdown by one tick and return the result it gives.
    function automatic result_t advance_tick(input logic [TEMP_W-1:0] temp,
                                             input logic sa, input logic sb,
                                             input logic sc);
        logic [TEMP_W-1:0]   lim;
        logic [LENGTH_W-1:0] len;
        result_t             r;

        r = '0;
        if (sa)
        begin
            lim = lim_a;
            len = len_a;
        end
        else if (sb)
        begin
            lim = lim_b;
            len = len_b;
        end
        else if (sc)
        begin
            lim = lim_c;
            len = len_c;
        end
        else
        begin
            lim = NO_SWITCH_LIMIT;
            len = '0;
        end

        if (temp >= lim && temp > last_temp && last_temp < lim && !counting && len != '0)
        begin
            if (len > MAX_LENGTH)
                len = MAX_LENGTH;
            motors[0]  = 1'b1;
            run_length = len;
            secs_to_go = len;
            counting   = 1'b1;
            starts_seen++;
        end
        last_temp = temp;

        if (counting)
        begin
            r.show_time    = 1'b1;
            r.minutes_left = MIN_W'(secs_to_go / SECS_PER_MINUTE);
            r.seconds_left = SEC_W'(secs_to_go % SECS_PER_MINUTE);
            if (secs_to_go == '0)
            begin
                counting = 1'b0;
                alarm    = 1'b1;
                alarms_seen++;
            end
            else
                secs_to_go = secs_to_go - 1'b1;
        end

        if (!sa && !sb && !sc)
        begin
            alarm      = 1'b0;
            extra_done = 1'b0;
        end

        if (alarm && !extra_done)
        begin
            motors[2:1] = 2'b11;
            extra_done  = 1'b1;
        end

        r.total_length = run_length;
        r.running      = counting;
        r.buzzer_on    = alarm;
        r.motor_one    = motors[0];
        r.motor_two    = motors[1];
        r.motor_three  = motors[2];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("result %0d, %s: expected %0d, got %0d", ticks_checked, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;

        if (!rst_n)
        begin
            lim_a         = 10'd30;
            lim_b         = 10'd50;
            lim_c         = 10'd70;
            len_a         = 13'd12;
            len_b         = 13'd12;
            len_c         = 13'd12;
            last_temp     = '0;
            secs_to_go    = '0;
            run_length    = '0;
            counting      = 1'b0;
            alarm         = 1'b0;
            extra_done    = 1'b0;
            motors        = '0;
            mismatches    = 0;
            ticks_checked = 0;
            starts_seen   = 0;
            alarms_seen   = 0;
            expected_q.delete();
            in_flight    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    IDX_LIMIT_A:  lim_a = cfg.data[TEMP_W-1:0];
                    IDX_LIMIT_B:  lim_b = cfg.data[TEMP_W-1:0];
                    IDX_LIMIT_C:  lim_c = cfg.data[TEMP_W-1:0];
                    IDX_LENGTH_A: len_a = cfg.data;
                    IDX_LENGTH_B: len_b = cfg.data;
                    IDX_LENGTH_C: len_c = cfg.data;
                    default: ;
                endcase
            end

            // compare before queuing: a tick taken at this edge cannot have
            // its result out yet
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no tick waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("show_time",    want.show_time,    result.show_time);
                    check_field("minutes_left", want.minutes_left, result.minutes_left);
                    check_field("seconds_left", want.seconds_left, result.seconds_left);
                    check_field("total_length", want.total_length, result.total_length);
                    check_field("running",      want.running,      result.running);
                    check_field("buzzer_on",    want.buzzer_on,    result.buzzer_on);
                    check_field("motor_one",    want.motor_one,    result.motor_one);
                    check_field("motor_two",    want.motor_two,    result.motor_two);
                    check_field("motor_three",  want.motor_three,  result.motor_three);
                    ticks_checked++;
                end
            end

            if (tick.valid && tick.ready)
                expected_q.push_back(advance_tick(tick.temperature, tick.switch_a,
                                                  tick.switch_b, tick.switch_c));

            in_flight <= expected_q.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Roast profile threshold timer testbench
// Drives temperature ticks and profile register writes into the timer with
// random source gaps and result stalls. A separate checker predicts every
// result; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rpt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 6;
    localparam int BLOCK_TICKS  = 170;
    // enough switch-off ticks to run out the longest countdown used in blocks
    localparam int FLUSH_TICKS  = 140;

    // register indexes past the end of the register list
    localparam logic [INDEX_W-1:0] IDX_SPARE_6 = 3'd6;
    localparam logic [INDEX_W-1:0] IDX_SPARE_7 = 3'd7;

    localparam int PROFILE_A = 0;
    localparam int PROFILE_B = 1;
    localparam int PROFILE_C = 2;

    typedef enum int {SET_TYPICAL, SET_MINUTES, SET_EDGES} setting_t;

    logic clk;
    logic rst_n;

    int src_gap_pct    = 16;
    int sink_stall_pct = 55;
    int hold_left      = 0;
    bit long_hold_req  = 1'b0;
    int ticks_sent     = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    // what the stimulus has written, so that it can aim at the limits
    int limit_set  [3] = '{30, 50, 70};
    int length_set [3] = '{12, 12, 12};

    int mismatches;
    int in_flight;
    int ticks_checked;
    int starts_seen;
    int alarms_seen;

    rpt_tick_if   tick_ch();
    rpt_result_if result_ch();
    rpt_cfg_if    cfg_ch();

    roast_profile_threshold_timer_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    roast_timer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .mismatches    (mismatches),
        .in_flight     (in_flight),
        .ticks_checked (ticks_checked),
        .starts_seen   (starts_seen),
        .alarms_seen   (alarms_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request. The
    // hold is counted here so the source keeps offering ticks meanwhile.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, in_flight);
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one tick, after a random gap, and hold it until taken. Valid
    // stays high between back-to-back ticks.
    task automatic send_tick(input logic [TEMP_W-1:0] temp, input logic sa,
                             input logic sb, input logic sc);
        if ($urandom_range(99) < src_gap_pct)
        begin
            tick_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < src_gap_pct);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.temperature <= temp;
        tick_ch.switch_a    <= sa;
        tick_ch.switch_b    <= sb;
        tick_ch.switch_c    <= sc;
        do
        begin
            @(posedge clk);
        end
        while (!tick_ch.ready);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result is out, then let the pipe settle.
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        case (idx)
            IDX_LIMIT_A:  limit_set[PROFILE_A]  = value[TEMP_W-1:0];
            IDX_LIMIT_B:  limit_set[PROFILE_B]  = value[TEMP_W-1:0];
            IDX_LIMIT_C:  limit_set[PROFILE_C]  = value[TEMP_W-1:0];
            IDX_LENGTH_A: length_set[PROFILE_A] = value;
            IDX_LENGTH_B: length_set[PROFILE_B] = value;
            IDX_LENGTH_C: length_set[PROFILE_C] = value;
            default: ;
        endcase
    endtask

    // Load one set of profiles. Limit writes carry random junk above bit 9,
    // which the block must drop.
    task automatic apply_setting(input setting_t kind);
        logic [DATA_W-1:0] lim_word [3];
        logic [DATA_W-1:0] len_word [3];

        for (int p = 0; p < 3; p++)
        begin
            lim_word[p] = {3'($urandom_range(7)), TEMP_W'($urandom_range(1023, 1))};
            if (kind == SET_MINUTES)
                len_word[p] = DATA_W'($urandom_range(130, 55));
            else
                len_word[p] = DATA_W'($urandom_range(20, 1));
        end
        if (kind == SET_EDGES)
        begin
            // A can never cross, B only at full scale, C has no length
            lim_word[PROFILE_A] = {3'($urandom_range(7)), TEMP_W'(0)};
            lim_word[PROFILE_B] = '1;
            len_word[PROFILE_C] = '0;
        end

        write_reg(IDX_LIMIT_A, lim_word[PROFILE_A]);
        write_reg(IDX_LENGTH_A, len_word[PROFILE_A]);
        write_reg(IDX_LIMIT_B, lim_word[PROFILE_B]);
        write_reg(IDX_LENGTH_B, len_word[PROFILE_B]);
        write_reg(IDX_LIMIT_C, lim_word[PROFILE_C]);
        write_reg(IDX_LENGTH_C, len_word[PROFILE_C]);
        // stray write to an unused index must change nothing
        write_reg($urandom_range(1) ? IDX_SPARE_6 : IDX_SPARE_7, DATA_W'($urandom));
    endtask

    // One roast cycle: settle below the limit, cross it, ride the countdown
    // to zero and usually turn the switch off to silence the buzzer. A short
    // one stops a few ticks after the start and leaves the count running.
    task automatic crossing_episode(input bit cut_short);
        int                prof;
        int                len;
        int                follow;
        logic              sa;
        logic              sb;
        logic              sc;
        logic [TEMP_W-1:0] lim;

        prof = $urandom_range(PROFILE_C, PROFILE_A);
        sa   = (prof == PROFILE_A);
        sb   = (prof == PROFILE_B) || (sa && 1'($urandom_range(1)));
        sc   = (prof == PROFILE_C) || 1'($urandom_range(1));
        lim  = TEMP_W'(limit_set[prof]);
        len  = length_set[prof];
        if (len > MAX_LENGTH)
            len = MAX_LENGTH;

        repeat ($urandom_range(4, 1))
        begin
            if (lim == '0)
                send_tick(TEMP_W'($urandom_range(1023)), sa, sb, sc);
            else
                send_tick(TEMP_W'($urandom_range(lim - 1)), sa, sb, sc);
        end
        send_tick(TEMP_W'($urandom_range(1023, lim)), sa, sb, sc);

        follow = cut_short ? $urandom_range(3, 1) : len + $urandom_range(4, 1);
        repeat (follow)
        begin
            // now and then all switches off mid-count
            if ($urandom_range(9) == 0)
                send_tick(TEMP_W'($urandom_range(1023)), 1'b0, 1'b0, 1'b0);
            else
                send_tick(TEMP_W'($urandom_range(1023)), sa, sb, sc);
        end

        if (!cut_short && $urandom_range(9) < 7)
        begin
            repeat ($urandom_range(2, 1))
                send_tick(TEMP_W'($urandom_range(1023)), 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Mostly roast cycles, some random noise. Pause once halfway until all
    // results are back; optionally ask the result side for a long hold.
    task automatic run_block(input int quota, input bit hold_off);
        int first;
        bit paused;

        first  = ticks_sent;
        paused = 1'b0;
        if (hold_off)
            long_hold_req = 1'b1;
        while (ticks_sent - first < quota)
        begin
            if (!paused && ticks_sent - first >= quota / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 75)
                crossing_episode(1'b0);
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_tick(TEMP_W'($urandom_range(1023)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        // leave a count running so the next register writes land mid-count
        crossing_episode(1'b1);
    endtask

    initial
    begin
        setting_t plan [3][3];

        plan = '{'{SET_TYPICAL, SET_EDGES,   SET_MINUTES},
                 '{SET_TYPICAL, SET_MINUTES, SET_EDGES},
                 '{SET_EDGES,   SET_TYPICAL, SET_TYPICAL}};

        // hold every input at a known value through reset
        rst_n               <= 1'b0;
        tick_ch.valid       <= 1'b0;
        tick_ch.temperature <= '0;
        tick_ch.switch_a    <= 1'b0;
        tick_ch.switch_b    <= 1'b0;
        tick_ch.switch_c    <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= IDX_LIMIT_A;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset profiles (30/50/70 degrees, 12 s).
        // Nothing selected, then a jump past the no-switch limit: no start.
        send_tick(10'd0, 1'b0, 1'b0, 1'b0);
        send_tick(10'd1023, 1'b0, 1'b0, 1'b0);
        // all switches: A wins; climb to exactly the limit to start 0:12
        send_tick(10'd10, 1'b1, 1'b1, 1'b1);
        send_tick(10'd29, 1'b1, 1'b0, 1'b0);
        send_tick(10'd30, 1'b1, 1'b1, 1'b1);
        // switches off mid-count: the count goes on
        send_tick(10'd0, 1'b0, 1'b0, 1'b0);
        // B crossing while running must not restart
        send_tick(10'd1023, 1'b0, 1'b1, 1'b0);
        // run down 0:09 .. 0:00; the last one raises the buzzer and motors
        for (int i = 0; i < 10; i++)
            send_tick(TEMP_W'(100 * i), 1'b0, 1'b0, 1'b1);
        // buzzer holds while a switch is on, switch off clears it
        send_tick(10'd500, 1'b0, 1'b0, 1'b1);
        send_tick(10'd5, 1'b0, 1'b0, 1'b0);
        // restart from low, then a flat reading that is not a rise
        send_tick(10'd1023, 1'b1, 1'b1, 1'b1);
        send_tick(10'd1023, 1'b1, 1'b0, 1'b0);
        wait_idle();

        // Three idling regimes: source gaps light / result stalls heavy,
        // the other way round, then full rate.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_gap_pct    = 16;
                    sink_stall_pct = 55;
                end
                1:
                begin
                    src_gap_pct    = 55;
                    sink_stall_pct = 16;
                end
                default:
                begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int b = 0; b < 3; b++)
            begin
                apply_setting(plan[ph][b]);
                run_block(BLOCK_TICKS, b == 1);
                wait_idle();
            end
        end

        // Run out any count with switches off, then start an oversized
        // length that must saturate to 99:59.
        repeat (FLUSH_TICKS)
            send_tick(TEMP_W'($urandom_range(1023)), 1'b0, 1'b0, 1'b0);
        wait_idle();
        write_reg(IDX_LIMIT_A, {3'b111, 10'd100});
        write_reg(IDX_LENGTH_A, '1);
        write_reg(IDX_LENGTH_B, MAX_LENGTH);
        write_reg(IDX_LIMIT_C, '1);
        src_gap_pct    = 16;
        sink_stall_pct = 16;
        send_tick(10'd40, 1'b1, 1'b0, 1'b0);
        send_tick(10'd1023, 1'b1, 1'b1, 1'b0);
        repeat (30)
            send_tick(TEMP_W'($urandom_range(1023)), 1'b1, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        wait_idle();

        $display("Covered %0d ticks and %0d register writes; %0d results checked.",
                 ticks_sent, reg_writes, ticks_checked);
        $display("Countdowns started: %0d, buzzer responses: %0d, mismatches: %0d.",
                 starts_seen, alarms_seen, mismatches);
        if (mismatches == 0 && in_flight == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
